// ===== rtl/core/dtr_pkg.sv =====
// Shared types, codes and helpers for the divider/timer block.
package dtr_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    REG_DIV  = 2'd0,
    REG_TIMA = 2'd1,
    REG_TMA  = 2'd2,
    REG_TAC  = 2'd3
  } reg_sel_t;

  typedef enum logic [1:0] {
    TAP_BIT9 = 2'd0,
    TAP_BIT3 = 2'd1,
    TAP_BIT5 = 2'd2,
    TAP_BIT7 = 2'd3
  } tap_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TICK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec_op;
    logic tick_step;
    logic finish;
  } dtr_cmd_t;

  typedef struct packed {
    logic tick_run;
    logic last_step;
  } dtr_sts_t;

  localparam logic [7:0] TIMA_MAX      = 8'hFF;
  localparam int unsigned TAC_EN_BIT   = 2;

  function automatic logic tap_level(input logic [9:0] div_low, input logic [1:0] sel);
    logic lvl;
    unique case (tap_t'(sel))
      TAP_BIT9: lvl = div_low[9];
      TAP_BIT3: lvl = div_low[3];
      TAP_BIT5: lvl = div_low[5];
      TAP_BIT7: lvl = div_low[7];
      default:  lvl = 1'b0;
    endcase
    return lvl;
  endfunction

endpackage

// ===== rtl/core/dtr_ctrl.sv =====
// Controller state machine sequencing request execution and result delivery.
module dtr_ctrl
  import dtr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dtr_sts_t sts,
  output dtr_cmd_t cmd
);

  state_t state, state_next;
  logic   out_ok;

  assign out_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec_op || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.tick_run) state_next = S_TICK;
        else if (out_ok) state_next = S_IDLE;
      end
      S_TICK: begin
        if (sts.last_step) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_ok) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_EXEC: begin
        cmd.exec_op = !sts.tick_run && out_ok;
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
      end
      S_FIN: begin
        cmd.finish = out_ok;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/dtr_dp.sv =====
// Datapath holding the divider, the timer registers and the result register.
module dtr_dp
  import dtr_pkg::*;
#(
  parameter int unsigned DIVIDER_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] req_type,
  input  logic [1:0] reg_sel,
  input  logic [7:0] write_data,
  input  logic [5:0] cycle_count,
  input  dtr_cmd_t   cmd,
  output dtr_sts_t   sts,
  output logic [7:0] read_data,
  output logic       timer_irq
);

  req_t                     req_q;
  reg_sel_t                 sel_q;
  logic [7:0]               data_q;
  logic [5:0]               count_q;
  logic [DIVIDER_WIDTH-1:0] divider, divider_next;
  logic [7:0]               tima, tima_next;
  logic [7:0]               tma, tma_next;
  logic [7:0]               tac, tac_next;
  logic                     acc, acc_next;
  logic [7:0]               rd_next;
  logic                     irq_next;

  logic                     ovf;
  logic [7:0]               tima_inc;
  logic [DIVIDER_WIDTH-1:0] div_inc;
  logic                     tap_now;

  assign ovf      = (tima == TIMA_MAX);
  assign tima_inc = ovf ? tma : tima + 8'd1;
  assign div_inc  = divider + DIVIDER_WIDTH'(1);
  assign tap_now  = tap_level(divider[9:0], tac[1:0]);

  assign sts.tick_run  = (req_q == REQ_TICK) && tac[TAC_EN_BIT] && (count_q != 6'd0);
  assign sts.last_step = (count_q == 6'd1);

  always_comb begin
    divider_next = divider;
    tima_next    = tima;
    tma_next     = tma;
    tac_next     = tac;
    acc_next     = acc;
    rd_next      = 8'd0;
    irq_next     = 1'b0;
    if (cmd.latch) begin
      acc_next = 1'b0;
    end
    if (cmd.exec_op) begin
      case (req_q)
        REQ_TICK: begin
          divider_next = divider + DIVIDER_WIDTH'(count_q);
        end
        REQ_READ: begin
          unique case (sel_q)
            REG_DIV:  rd_next = divider[DIVIDER_WIDTH-1 -: 8];
            REG_TIMA: rd_next = tima;
            REG_TMA:  rd_next = tma;
            REG_TAC:  rd_next = tac;
            default:  rd_next = 8'd0;
          endcase
        end
        REQ_WRITE: begin
          unique case (sel_q)
            REG_DIV: begin
              if (tap_now) begin
                tima_next = tima_inc;
                irq_next  = ovf;
              end
              divider_next = '0;
            end
            REG_TIMA: tima_next = data_q;
            REG_TMA:  tma_next  = data_q;
            REG_TAC: begin
              tac_next = data_q;
              if (tap_now && !tap_level(divider[9:0], data_q[1:0])) begin
                tima_next = tima_inc;
                irq_next  = ovf;
              end
            end
            default: tac_next = tac;
          endcase
        end
        default: begin
          rd_next = 8'd0;
        end
      endcase
    end
    if (cmd.tick_step) begin
      divider_next = div_inc;
      if (tap_now && !tap_level(div_inc[9:0], tac[1:0])) begin
        tima_next = tima_inc;
        acc_next  = acc | ovf;
      end
    end
    if (cmd.finish) begin
      irq_next = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider <= '0;
      tima    <= 8'd0;
      tma     <= 8'd0;
      tac     <= 8'd0;
      acc     <= 1'b0;
    end else begin
      divider <= divider_next;
      tima    <= tima_next;
      tma     <= tma_next;
      tac     <= tac_next;
      acc     <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q   <= req_t'(req_type);
      sel_q   <= reg_sel_t'(reg_sel);
      data_q  <= write_data;
      count_q <= cycle_count;
    end else if (cmd.tick_step) begin
      count_q <= count_q - 6'd1;
    end
    if (cmd.exec_op || cmd.finish) begin
      read_data <= rd_next;
      timer_irq <= irq_next;
    end
  end

endmodule

// ===== rtl/core/divider_timer_with_reload_top.sv =====
// Top level of the DIV/TIMA/TMA/TAC divider and timer block.
//
//   channel | signals                                         | role
//   --------+-------------------------------------------------+--------------------------
//   in      | in_valid, in_ready, req_type, reg_sel,           | request beat: tick, read
//           | write_data, cycle_count                          | or write
//   out     | out_valid, out_ready, read_data, timer_irq       | one result beat per request
//
// Reads, writes, unused requests and ticks with the timer disabled or a zero cycle_count
// run in EXEC. A tick with the timer enabled and a nonzero cycle_count steps the divider
// in TICK, one divider step per clock. One request is in flight at a time; its divider
// steps run while the previous result still waits. A stalled output holds the block in
// EXEC or FIN. Reset is synchronous and clears the divider and all timer registers.
module divider_timer_with_reload_top
  import dtr_pkg::*;
#(
  parameter int unsigned DIVIDER_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [1:0] reg_sel,
  input  logic [7:0] write_data,
  input  logic [5:0] cycle_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       timer_irq
);

  dtr_cmd_t cmd;
  dtr_sts_t sts;

  dtr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtr_dp #(
    .DIVIDER_WIDTH (DIVIDER_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_type    (req_type),
    .reg_sel     (reg_sel),
    .write_data  (write_data),
    .cycle_count (cycle_count),
    .cmd         (cmd),
    .sts         (sts),
    .read_data   (read_data),
    .timer_irq   (timer_irq)
  );

endmodule

// ===== rtl/core/dtr_chk.sv =====
// Port-level checker for the divider/timer block and its bind to the top level.
module dtr_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] req_type,
  input logic [1:0] reg_sel,
  input logic [7:0] write_data,
  input logic [5:0] cycle_count,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       timer_irq
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(timer_irq))
    else $error("Result beat changed while stalled.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted while a request was in flight.");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid after reset.");

  a_irq_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && timer_irq |-> read_data == 8'd0)
    else $error("Interrupt beat carries read data.");

endmodule

bind divider_timer_with_reload_top dtr_chk u_dtr_chk (.*);
